// File: rtl/arp_udp_frame_classifier_macros.svh
// ----------------------------------------------------------------------------
// ARP/UDP frame classifier assertion macros
// Shared assertion shorthands for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ARP_UDP_FRAME_CLASSIFIER_MACROS_SVH
`define ARP_UDP_FRAME_CLASSIFIER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication check that is switched off while reset is held.
`define AUC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("classifier implication check failed");
// Implication check that also runs through reset.
`define AUC_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("classifier reset check failed");
`else
`define AUC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define AUC_ASSERT_ALWAYS(lbl, clk, ante, cons)
`endif
`endif

// File: rtl/auc_pkg.sv
// ----------------------------------------------------------------------------
// ARP/UDP frame classifier package
// Types, header offsets and codes shared by the classifier modules.
// ----------------------------------------------------------------------------
package auc_pkg;

    localparam int MAX_FRAME_LEN_DEF = 16383;
    localparam int MIN_LEN           = 42;
    localparam int QUEUE_DEPTH       = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_MAGIC = 1'd1;

    // Byte offsets inside the frame.
    localparam int POS_TYPE_HI   = 12;
    localparam int POS_TYPE_LO   = 13;
    localparam int POS_14        = 14;
    localparam int POS_15        = 15;
    localparam int POS_16        = 16;
    localparam int POS_17        = 17;
    localparam int POS_18        = 18;
    localparam int POS_19        = 19;
    localparam int POS_20        = 20;
    localparam int POS_21        = 21;
    localparam int POS_IP_PROTO  = 23;
    localparam int POS_SMAC_LO   = 22;
    localparam int POS_SMAC_HI   = 27;
    localparam int POS_SIP_LO    = 28;
    localparam int POS_SIP_HI    = 31;
    localparam int POS_TIP_LO    = 38;
    localparam int POS_TIP_HI    = 41;
    localparam int POS_PAY_LO    = 42;
    localparam int POS_PAY_HI    = 49;

    // Expected header bytes.
    localparam logic [7:0] ETH_TYPE_HI   = 8'h08;
    localparam logic [7:0] ETH_ARP_LO    = 8'h06;
    localparam logic [7:0] ETH_IPV4_LO   = 8'h00;
    localparam logic [7:0] ARP_HTYPE_HI  = 8'h00;
    localparam logic [7:0] ARP_HTYPE_LO  = 8'h01;
    localparam logic [7:0] ARP_PTYPE_HI  = 8'h08;
    localparam logic [7:0] ARP_PTYPE_LO  = 8'h00;
    localparam logic [7:0] ARP_HLEN      = 8'h06;
    localparam logic [7:0] ARP_PLEN      = 8'h04;
    localparam logic [7:0] ARP_OP_HI     = 8'h00;
    localparam logic [7:0] ARP_OP_LO     = 8'h01;
    localparam logic [7:0] IPV4_VER_IHL  = 8'h45;
    localparam logic [7:0] IP_PROTO_UDP  = 8'h11;

    localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
    localparam logic [16:0] UDP_LEN_BIAS  = 17'd34;
    localparam logic [15:0] MAGIC_PAY_LEN = 16'd8;

    typedef enum logic [1:0] {
        VERDICT_OTHER  = 2'd0,
        VERDICT_ARP    = 2'd1,
        VERDICT_REBOOT = 2'd2,
        VERDICT_UDP    = 2'd3
    } t_verdict;

    // Everything the back end needs from one finished frame.
    typedef struct packed {
        logic        len_ok;
        logic        arp_hdr_ok;
        logic        udp_hdr_ok;
        logic        udp_len_ok;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] target_word;
        logic [63:0] payload;
    } t_frame_rec;

endpackage

// File: rtl/auc_front.sv
// ----------------------------------------------------------------------------
// Classifier front end
// Counts frame bytes, checks header bytes on the fly and captures fields.
// ----------------------------------------------------------------------------
module auc_front #(
    parameter int MAX_FRAME_LEN = auc_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output logic               o_push,
    output auc_pkg::t_frame_rec o_rec
);
    import auc_pkg::*;

    localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1);

    logic [LEN_W-1:0] r_pos, n_pos;
    logic             r_arp_ok, n_arp_ok;
    logic             r_ip_ok, n_ip_ok;
    logic [47:0]      r_mac, n_mac;
    logic [31:0]      r_sip, n_sip;
    logic [31:0]      r_tip, n_tip;
    logic [63:0]      r_pay, n_pay;
    logic             arp_base, ip_base;
    logic [16:0]      ulen_end;

    function automatic logic at(input logic [LEN_W-1:0] pos, input int off);
        at = (pos == LEN_W'(off));
    endfunction

    always_comb begin
        n_pos = (r_pos == LEN_W'(MAX_FRAME_LEN)) ? r_pos : r_pos + LEN_W'(1);

        // Match flags restart on the first byte of each frame.
        arp_base = (r_pos == '0) ? 1'b1 : r_arp_ok;
        ip_base  = (r_pos == '0) ? 1'b1 : r_ip_ok;
        n_arp_ok = arp_base;
        n_ip_ok  = ip_base;
        unique case (1'b1)
            at(r_pos, POS_TYPE_HI): begin
                n_arp_ok = arp_base & (i_byte == ETH_TYPE_HI);
                n_ip_ok  = ip_base & (i_byte == ETH_TYPE_HI);
            end
            at(r_pos, POS_TYPE_LO): begin
                n_arp_ok = arp_base & (i_byte == ETH_ARP_LO);
                n_ip_ok  = ip_base & (i_byte == ETH_IPV4_LO);
            end
            at(r_pos, POS_14): begin
                n_arp_ok = arp_base & (i_byte == ARP_HTYPE_HI);
                n_ip_ok  = ip_base & (i_byte == IPV4_VER_IHL);
            end
            at(r_pos, POS_15): n_arp_ok = arp_base & (i_byte == ARP_HTYPE_LO);
            at(r_pos, POS_16): n_arp_ok = arp_base & (i_byte == ARP_PTYPE_HI);
            at(r_pos, POS_17): n_arp_ok = arp_base & (i_byte == ARP_PTYPE_LO);
            at(r_pos, POS_18): n_arp_ok = arp_base & (i_byte == ARP_HLEN);
            at(r_pos, POS_19): n_arp_ok = arp_base & (i_byte == ARP_PLEN);
            at(r_pos, POS_20): n_arp_ok = arp_base & (i_byte == ARP_OP_HI);
            at(r_pos, POS_21): n_arp_ok = arp_base & (i_byte == ARP_OP_LO);
            at(r_pos, POS_IP_PROTO): n_ip_ok = ip_base & (i_byte == IP_PROTO_UDP);
            default: ;
        endcase

        n_mac = r_mac;
        n_sip = r_sip;
        n_tip = r_tip;
        n_pay = r_pay;
        if (r_pos >= LEN_W'(POS_SMAC_LO) && r_pos <= LEN_W'(POS_SMAC_HI)) begin
            n_mac = {r_mac[39:0], i_byte};
        end
        if (r_pos >= LEN_W'(POS_SIP_LO) && r_pos <= LEN_W'(POS_SIP_HI)) begin
            n_sip = {r_sip[23:0], i_byte};
        end
        if (r_pos >= LEN_W'(POS_TIP_LO) && r_pos <= LEN_W'(POS_TIP_HI)) begin
            n_tip = {r_tip[23:0], i_byte};
        end
        // Payload is little-endian: the first byte ends up in the low bits.
        if (r_pos >= LEN_W'(POS_PAY_LO) && r_pos <= LEN_W'(POS_PAY_HI)) begin
            n_pay = {i_byte, r_pay[63:8]};
        end
    end

    // The UDP length sits in the top half of the target word (bytes 38..39).
    assign ulen_end = {1'b0, n_tip[31:16]} + UDP_LEN_BIAS;

    always_comb begin
        o_push            = i_accept & i_last;
        o_rec.len_ok      = (n_pos >= LEN_W'(MIN_LEN));
        o_rec.arp_hdr_ok  = n_arp_ok;
        o_rec.udp_hdr_ok  = n_ip_ok;
        o_rec.udp_len_ok  = (n_tip[31:16] >= UDP_HDR_LEN) &&
                            (ulen_end <= 17'(n_pos));
        o_rec.src_mac     = n_mac;
        o_rec.src_ip      = n_sip;
        o_rec.target_word = n_tip;
        o_rec.payload     = n_pay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= i_last ? '0 : n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_arp_ok <= n_arp_ok;
            r_ip_ok  <= n_ip_ok;
            r_mac    <= n_mac;
            r_sip    <= n_sip;
            r_tip    <= n_tip;
            r_pay    <= n_pay;
        end
    end

endmodule

// File: rtl/auc_queue.sv
// ----------------------------------------------------------------------------
// Classifier frame queue
// Small FIFO of finished frame records between the front and back ends.
// ----------------------------------------------------------------------------
module auc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  auc_pkg::t_frame_rec i_rec,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output auc_pkg::t_frame_rec o_rec
);
    import auc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame_rec       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wp  = do_push ? ((r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1)) : r_wp;
        n_rp  = do_pop ? ((r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1)) : r_rp;
        n_cnt = r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

endmodule

// File: rtl/auc_back.sv
// ----------------------------------------------------------------------------
// Classifier back end
// Compares captured fields with the configuration and registers the verdict.
// ----------------------------------------------------------------------------
module auc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  auc_pkg::t_frame_rec i_rec,
    output logic                o_pop,
    input  logic [31:0]         i_own_ip,
    input  logic [63:0]         i_magic,
    output logic                o_valid,
    input  logic                i_ready,
    output auc_pkg::t_verdict   o_verdict,
    output logic [47:0]         o_sender_mac,
    output logic [31:0]         o_sender_ip,
    output logic [15:0]         o_payload_len
);
    import auc_pkg::*;

    logic        r_valid;
    t_verdict    r_verdict, n_verdict;
    logic [47:0] r_mac, n_mac;
    logic [31:0] r_sip, n_sip;
    logic [15:0] r_plen, n_plen;
    logic        is_arp, is_udp;
    logic [15:0] plen;

    assign o_pop = ~i_empty & (~r_valid | i_ready);

    always_comb begin
        plen   = i_rec.target_word[31:16] - UDP_HDR_LEN;
        is_arp = i_rec.len_ok & i_rec.arp_hdr_ok & (i_rec.target_word == i_own_ip);
        is_udp = i_rec.len_ok & i_rec.udp_hdr_ok & i_rec.udp_len_ok;
        n_verdict = VERDICT_OTHER;
        n_mac     = '0;
        n_sip     = '0;
        n_plen    = '0;
        priority if (is_arp) begin
            n_verdict = VERDICT_ARP;
            n_mac     = i_rec.src_mac;
            n_sip     = i_rec.src_ip;
        end else if (is_udp) begin
            n_plen    = plen;
            n_verdict = (plen == MAGIC_PAY_LEN && i_rec.payload == i_magic) ?
                        VERDICT_REBOOT : VERDICT_UDP;
        end else begin
            n_verdict = VERDICT_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (~r_valid | i_ready) begin
            r_valid <= ~i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_verdict <= n_verdict;
            r_mac     <= n_mac;
            r_sip     <= n_sip;
            r_plen    <= n_plen;
        end
    end

    assign o_valid       = r_valid;
    assign o_verdict     = r_verdict;
    assign o_sender_mac  = r_mac;
    assign o_sender_ip   = r_sip;
    assign o_payload_len = r_plen;

endmodule

// File: rtl/arp_udp_frame_classifier.sv
// ----------------------------------------------------------------------------
// ARP/UDP frame classifier
// Receive-side classifier giving one verdict per Ethernet frame.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one frame byte per beat in tdata, with tlast on
// the final byte. The block accepts one byte every cycle while the queue is
// not full. Header fields are checked and captured as the bytes go by, so no
// frame buffer is needed. On the last byte the captured record enters a
// two-entry queue; the back end compares it with own_ip and reboot_magic and
// presents one result beat on the output stream. The queue is written when
// the last byte is accepted; the output register loads from the queue head
// once it is free, and o_m_tvalid rises. Sustained rate is one byte per cycle
// while the queue is not full; back-to-back one-byte frames give one result
// per cycle while the output is not stalled. When the receiver stalls,
// results wait in the output register and the queue; input tready drops only
// when the queue is full. Reset clears the byte counter, the queue and the
// output valid, and sets both configuration registers to zero. Configuration
// is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so only
// while no frame is in flight, which the block itself does not enforce.
// Frames longer than MAX_FRAME_LEN bytes are counted as MAX_FRAME_LEN long.
// ----------------------------------------------------------------------------
`include "arp_udp_frame_classifier_macros.svh"

module arp_udp_frame_classifier #(
    parameter int MAX_FRAME_LEN = auc_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream: tdata = data_byte[7:0]; tlast = last_byte.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,
    input  logic                           i_s_tlast,
    // Result stream: tdata = src_mac[47:0], src_ip[79:48],
    // payload_len[95:80].
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [95:0]                    o_m_tdata,
    // tuser = verdict[1:0].
    output logic [1:0]                     o_m_tuser,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [auc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [63:0]                    i_cfg_data
);
    import auc_pkg::*;

    logic [31:0] r_own_ip;
    logic [63:0] r_magic;
    logic        accept;
    logic        push, pop, q_full, q_empty;
    t_frame_rec  front_rec, head_rec;
    t_verdict    verdict;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [15:0] plen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
            r_magic  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN_IP:       r_own_ip <= i_cfg_data[31:0];
                CFG_REBOOT_MAGIC: r_magic  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_tready = ~q_full;
    assign accept     = i_s_tvalid & o_s_tready;

    auc_front #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    auc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rec   (head_rec)
    );

    auc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_rec         (head_rec),
        .o_pop         (pop),
        .i_own_ip      (r_own_ip),
        .i_magic       (r_magic),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_verdict     (verdict),
        .o_sender_mac  (smac),
        .o_sender_ip   (sip),
        .o_payload_len (plen)
    );

    assign o_m_tdata = {plen, sip, smac};
    assign o_m_tuser = verdict;

    // ARP fields appear only with an ARP verdict, the length only with UDP ones.
    `AUC_ASSERT_IMPL(a_arp_fields, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != VERDICT_ARP, o_m_tdata[79:0] == 80'd0)
    `AUC_ASSERT_IMPL(a_len_field, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == VERDICT_ARP || o_m_tuser == VERDICT_OTHER), o_m_tdata[95:80] == 16'd0)
    // A reboot verdict always carries an 8-byte payload length.
    `AUC_ASSERT_IMPL(a_reboot_len, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == VERDICT_REBOOT, o_m_tdata[95:80] == MAGIC_PAY_LEN)
    `AUC_ASSERT_ALWAYS(a_reset_idle, i_clk, $past(!i_rst_n), !o_m_tvalid && o_s_tready)

endmodule
